/* rtl/bta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared codes and constants of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

   // request commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // response status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd2;

   // heap layout
   localparam int unsigned FIRST_PAYLOAD = 16;
   localparam logic [31:0] TAG_ALLOC     = 32'd1;
   localparam logic [31:0] PROLOGUE_TAG  = 32'd9;

endpackage

/* rtl/boundary_tag_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Implicit free list allocator over a tag memory, best or first fit.
// Allocate walks the blocks, then grows, merges and splits as needed; free
// walks the blocks up to the target, then marks it free and merges. One
// request at a time; the single memory port sets the pace.
// Reset formats the heap; the tag memory is not cleared.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator
   import bta_pkg::*;
#(
   parameter int unsigned HEAP_BYTES  = 65536,
   parameter int unsigned CHUNK_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_block_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_payload_offset,
   output logic [1:0]  rsp_status
);

   localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
   localparam int unsigned AW         = $clog2(HEAP_WORDS);
   localparam int unsigned HB_W       = $clog2(HEAP_BYTES);
   localparam int unsigned OW         = ((HB_W > 17) ? HB_W : 17) + 2;
   localparam int unsigned CHUNK_G    =
      ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_WALK_RD, S_WALK_CK, S_WALK_END, S_GROW,
      S_EXT1, S_EXT2, S_EXT3, S_FREE_W1, S_FREE_W2,
      S_MRG_P, S_MRG_N, S_MRG_W1, S_MRG_W2,
      S_CRV_RD, S_CRV_W1, S_CRV_W2, S_CRV_W3, S_CRV_W4
   } state_type;

   typedef enum logic [1:0] {M_INIT, M_ALLOC, M_FREE} mode_type;

   state_type       state_ff;
   mode_type        mode_ff;
   logic [1:0]      cnt_ff;
   logic            policy_ff;
   logic [OW-1:0]   brk_ff, p_ff, cur_ff, sz_ff, tot_ff, start_ff;
   logic [OW-1:0]   need_ff, best_ff, best_sz_ff, have_ff;
   logic            hit_ff;
   logic [15:0]     off_ff;
   logic            rsp_valid_ff;
   logic [15:0]     rsp_off_ff;
   logic [1:0]      rsp_st_ff;

   // tag memory, one port
   logic [31:0]     mem [HEAP_WORDS];
   logic [31:0]     mem_q;
   logic [OW-1:0]   mem_off;
   logic            mem_we;
   logic [31:0]     mem_wdata;

   // decoded tag read back from memory
   logic [OW-1:0]   q_size;
   logic            q_alloc;
   logic [OW-1:0]   grow_g;
   logic [OW-1:0]   merge_total;

   assign q_size      = {mem_q[OW-1:3], 3'b000};
   assign q_alloc     = mem_q[0];
   assign grow_g      = (need_ff > OW'(CHUNK_BYTES)) ? need_ff : OW'(CHUNK_G);
   assign merge_total = tot_ff + (q_alloc ? '0 : q_size);

   assign req_stall          = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_status         = rsp_st_ff;

   // memory address and write data per state
   always_comb begin
      mem_off   = '0;
      mem_we    = 1'b0;
      mem_wdata = '0;
      case (state_ff)
         S_INIT: begin
            mem_off = OW'({cnt_ff, 2'b00});
            mem_we  = 1'b1;
            case (cnt_ff)
               2'd1, 2'd2: mem_wdata = PROLOGUE_TAG;
               2'd3:       mem_wdata = TAG_ALLOC;
               default:    mem_wdata = '0;
            endcase
         end
         S_WALK_RD: mem_off = p_ff - OW'(4);
         S_EXT1: begin
            mem_off = cur_ff - OW'(4); mem_we = 1'b1; mem_wdata = 32'(sz_ff);
         end
         S_EXT2, S_FREE_W2: begin
            mem_off = cur_ff + sz_ff - OW'(8); mem_we = 1'b1; mem_wdata = 32'(sz_ff);
         end
         S_EXT3: begin
            mem_off = cur_ff + sz_ff - OW'(4); mem_we = 1'b1; mem_wdata = TAG_ALLOC;
         end
         S_FREE_W1: begin
            mem_off = cur_ff - OW'(4); mem_we = 1'b1; mem_wdata = 32'(sz_ff);
         end
         S_MRG_P: mem_off = cur_ff - OW'(8);
         S_MRG_N: mem_off = cur_ff + sz_ff - OW'(4);
         S_MRG_W1: begin
            mem_off = start_ff - OW'(4); mem_we = 1'b1; mem_wdata = 32'(merge_total);
         end
         S_MRG_W2: begin
            mem_off = start_ff + tot_ff - OW'(8); mem_we = 1'b1;
            mem_wdata = 32'(tot_ff);
         end
         S_CRV_RD: mem_off = cur_ff - OW'(4);
         S_CRV_W1: begin
            mem_off = cur_ff - OW'(4); mem_we = 1'b1;
            mem_wdata = 32'(need_ff) | TAG_ALLOC;
         end
         S_CRV_W2: begin
            mem_off = cur_ff + need_ff - OW'(8); mem_we = 1'b1;
            mem_wdata = 32'(need_ff) | TAG_ALLOC;
         end
         S_CRV_W3: begin
            mem_off = cur_ff + need_ff - OW'(4); mem_we = 1'b1;
            mem_wdata = 32'(have_ff - need_ff);
         end
         S_CRV_W4: begin
            mem_off = cur_ff + have_ff - OW'(8); mem_we = 1'b1;
            mem_wdata = 32'(have_ff - need_ff);
         end
         default: mem_off = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we && (mem_off[OW-1:2] < (OW-2)'(HEAP_WORDS))) begin
         mem[mem_off[AW+1:2]] <= mem_wdata;
      end
      mem_q <= mem[mem_off[AW+1:2]];
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
      end else if (csr_wr_en) begin
         policy_ff <= csr_wr_data;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         mode_ff      <= M_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            // pad, prologue, epilogue, then the first chunk
            S_INIT: begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  brk_ff  <= OW'(FIRST_PAYLOAD);
                  mode_ff <= M_INIT;
                  if (FIRST_PAYLOAD + CHUNK_G <= HEAP_BYTES) begin
                     cur_ff   <= OW'(FIRST_PAYLOAD);
                     sz_ff    <= OW'(CHUNK_G);
                     state_ff <= S_EXT1;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  p_ff    <= OW'(FIRST_PAYLOAD);
                  hit_ff  <= 1'b0;
                  off_ff  <= req_block_offset;
                  need_ff <= (OW'(req_request_bytes) + OW'(15)) & ~OW'(7);
                  if (req_cmd == CMD_FREE) begin
                     mode_ff  <= M_FREE;
                     state_ff <= S_WALK_RD;
                  end else if (req_request_bytes == 16'd0) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_off_ff   <= '0;
                     rsp_st_ff    <= ST_ZERO_SIZE;
                  end else begin
                     mode_ff  <= M_ALLOC;
                     state_ff <= S_WALK_RD;
                  end
               end
            end
            // block walk: read header, then inspect
            S_WALK_RD: begin
               state_ff <= (p_ff < brk_ff) ? S_WALK_CK : S_WALK_END;
            end
            S_WALK_CK: begin
               state_ff <= S_WALK_RD;
               p_ff     <= p_ff + q_size;
               if (q_size == '0) begin
                  state_ff <= S_WALK_END;
               end else if (mode_ff == M_FREE) begin
                  if (p_ff == OW'(off_ff)) begin
                     cur_ff <= p_ff;
                     sz_ff  <= q_size;
                     state_ff <= q_alloc ? S_FREE_W1 : S_WALK_END;
                  end else if (p_ff > OW'(off_ff)) begin
                     state_ff <= S_WALK_END;
                  end
               end else if (!q_alloc && q_size >= need_ff) begin
                  if (policy_ff) begin
                     cur_ff   <= p_ff;
                     state_ff <= S_CRV_RD;
                  end else if (!hit_ff || q_size < best_sz_ff) begin
                     hit_ff     <= 1'b1;
                     best_ff    <= p_ff;
                     best_sz_ff <= q_size;
                  end
               end
            end
            S_WALK_END: begin
               if (mode_ff == M_FREE) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_off_ff   <= '0;
                  rsp_st_ff    <= ST_DONE;
                  state_ff     <= S_IDLE;
               end else if (hit_ff) begin
                  cur_ff   <= best_ff;
                  state_ff <= S_CRV_RD;
               end else begin
                  state_ff <= S_GROW;
               end
            end
            // nothing fits: extend the heap, or report no space when it would overflow
            S_GROW: begin
               if (brk_ff + grow_g > OW'(HEAP_BYTES)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_off_ff   <= '0;
                  rsp_st_ff    <= ST_NO_SPACE;
                  state_ff     <= S_IDLE;
               end else begin
                  cur_ff   <= brk_ff;
                  sz_ff    <= grow_g;
                  state_ff <= S_EXT1;
               end
            end
            S_EXT1: state_ff <= S_EXT2;
            S_EXT2: state_ff <= S_EXT3;
            S_EXT3: begin
               brk_ff   <= cur_ff + sz_ff;
               state_ff <= S_MRG_P;
            end
            S_FREE_W1: state_ff <= S_FREE_W2;
            S_FREE_W2: state_ff <= S_MRG_P;
            // coalesce with free neighbors
            S_MRG_P: state_ff <= S_MRG_N;
            S_MRG_N: begin
               tot_ff   <= sz_ff + (q_alloc ? '0 : q_size);
               start_ff <= cur_ff - (q_alloc ? '0 : q_size);
               state_ff <= S_MRG_W1;
            end
            S_MRG_W1: begin
               tot_ff   <= merge_total;
               state_ff <= S_MRG_W2;
            end
            S_MRG_W2: begin
               case (mode_ff)
                  M_INIT: state_ff <= S_IDLE;
                  M_FREE: begin
                     rsp_valid_ff <= 1'b1;
                     rsp_off_ff   <= '0;
                     rsp_st_ff    <= ST_DONE;
                     state_ff     <= S_IDLE;
                  end
                  default: begin
                     cur_ff   <= start_ff;
                     state_ff <= S_CRV_RD;
                  end
               endcase
            end
            // mark allocated and split off the rest
            S_CRV_RD: state_ff <= S_CRV_W1;
            S_CRV_W1: begin
               have_ff  <= q_size;
               state_ff <= S_CRV_W2;
            end
            S_CRV_W2: begin
               if (have_ff > need_ff) begin
                  state_ff <= S_CRV_W3;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_off_ff   <= cur_ff[15:0];
                  rsp_st_ff    <= ST_DONE;
                  state_ff     <= S_IDLE;
               end
            end
            S_CRV_W3: state_ff <= S_CRV_W4;
            S_CRV_W4: begin
               rsp_valid_ff <= 1'b1;
               rsp_off_ff   <= cur_ff[15:0];
               rsp_st_ff    <= ST_DONE;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* verif/bta_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_checker
// Watches the request and response channels of the heap allocator, keeps a
// tag-level model of the heap, predicts each response and compares it.
// ----------------------------------------------------------------------------
module bta_checker
   import bta_pkg::*;
#(
   parameter int unsigned HEAP_BYTES  = 65536,
   parameter int unsigned CHUNK_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_block_offset,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_payload_offset,
   input  logic [1:0]  rsp_status,
   output int          err_count,
   output int          pending
);

   localparam int unsigned NWORDS = HEAP_BYTES / 4;

   typedef struct packed {
      logic [15:0] offset;
      logic [1:0]  status;
   } alloc_result_type;

   logic [31:0]      tags [NWORDS];
   int unsigned      brk;
   logic             first_fit;
   alloc_result_type expected_q[$];

   function automatic logic [31:0] tag_rd(int unsigned off);
      return ((off >> 2) < NWORDS) ? tags[off >> 2] : 32'd0;
   endfunction

   function automatic void tag_wr(int unsigned off, logic [31:0] v);
      if ((off >> 2) < NWORDS) tags[off >> 2] = v;
   endfunction

   function automatic int unsigned even_words(int unsigned n);
      int unsigned w;
      w = n / 4;
      if (w[0]) w++;
      return w * 4;
   endfunction

   function automatic int unsigned coalesce(int unsigned bp);
      int unsigned sz, ptag, ntag, total, start;
      sz    = tag_rd(bp - 4) & ~32'h7;
      ptag  = tag_rd(bp - 8);
      ntag  = tag_rd(bp + sz - 4);
      total = sz;
      start = bp;
      if (!ptag[0]) begin
         total += ptag & ~32'h7;
         start = bp - (ptag & ~32'h7);
      end
      if (!ntag[0]) total += ntag & ~32'h7;
      if (total != sz || start != bp) begin
         tag_wr(start - 4, total);
         tag_wr(start + total - 8, total);
      end
      return start;
   endfunction

   function automatic int unsigned grow_heap(int unsigned size);
      int unsigned bp;
      bp = brk;
      tag_wr(bp - 4, size);
      tag_wr(bp + size - 8, size);
      tag_wr(bp + size - 4, TAG_ALLOC);
      brk = bp + size;
      return coalesce(bp);
   endfunction

   function automatic void split_block(int unsigned bp, int unsigned need);
      int unsigned have;
      have = tag_rd(bp - 4) & ~32'h7;
      tag_wr(bp - 4, need | 1);
      tag_wr(bp + need - 8, need | 1);
      if (have > need) begin
         tag_wr(bp + need - 4, have - need);
         tag_wr(bp + have - 8, have - need);
      end
   endfunction

   // walk the blocks for a free one that fits; 0 when none
   function automatic int unsigned search_fit(int unsigned need);
      int unsigned p, t, sz, best, best_sz;
      p = FIRST_PAYLOAD;
      best = 0;
      best_sz = 0;
      while (p < brk) begin
         t  = tag_rd(p - 4);
         sz = t & ~32'h7;
         if (sz == 0) break;
         if (!t[0] && sz >= need) begin
            if (first_fit) return p;
            if (best == 0 || sz < best_sz) begin
               best = p;
               best_sz = sz;
            end
         end
         p += sz;
      end
      return best;
   endfunction

   function automatic bit is_live_block(int unsigned off);
      int unsigned p, t, sz;
      p = FIRST_PAYLOAD;
      while (p < brk) begin
         t  = tag_rd(p - 4);
         sz = t & ~32'h7;
         if (sz == 0 || p > off) return 0;
         if (p == off) return t[0];
         p += sz;
      end
      return 0;
   endfunction

   function automatic void format_heap();
      int unsigned first;
      foreach (tags[i]) tags[i] = '0;
      first_fit = 1'b0;
      tag_wr(4, PROLOGUE_TAG);
      tag_wr(8, PROLOGUE_TAG);
      tag_wr(12, TAG_ALLOC);
      brk = FIRST_PAYLOAD;
      first = even_words(CHUNK_BYTES);
      if (FIRST_PAYLOAD + first <= HEAP_BYTES) void'(grow_heap(first));
   endfunction

   function automatic alloc_result_type serve(logic cmd, int unsigned nbytes,
                                              int unsigned off);
      alloc_result_type r;
      int unsigned need, bp, g, sz;
      r = '{offset: '0, status: ST_DONE};
      if (cmd == CMD_FREE) begin
         if (is_live_block(off)) begin
            sz = tag_rd(off - 4) & ~32'h7;
            tag_wr(off - 4, sz);
            tag_wr(off + sz - 8, sz);
            void'(coalesce(off));
         end
      end else if (nbytes == 0) begin
         r.status = ST_ZERO_SIZE;
      end else begin
         need = (nbytes + 15) & ~32'h7;
         bp = search_fit(need);
         if (bp != 0) begin
            split_block(bp, need);
            r.offset = bp[15:0];
         end else begin
            g = even_words(need > CHUNK_BYTES ? need : CHUNK_BYTES);
            if (brk + g > HEAP_BYTES) begin
               r.status = ST_NO_SPACE;
            end else begin
               bp = grow_heap(g);
               split_block(bp, need);
               r.offset = bp[15:0];
            end
         end
      end
      return r;
   endfunction

   // predict on accepted requests, compare accepted responses
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         format_heap();
         expected_q.delete();
         err_count <= 0;
         pending   <= 0;
      end else begin
         if (csr_wr_en) first_fit = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               err_count <= err_count + 1;
               if (err_count < 10)
                  $display("%t unexpected response off=%0d st=%0d", $realtime,
                           rsp_payload_offset, rsp_status);
            end else begin
               want = expected_q.pop_front();
               if (want.offset !== rsp_payload_offset || want.status !== rsp_status) begin
                  err_count <= err_count + 1;
                  if (err_count < 10)
                     $display("%t mismatch: exp off=%0d st=%0d, got off=%0d st=%0d",
                              $realtime, want.offset, want.status,
                              rsp_payload_offset, rsp_status);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(serve(req_cmd, req_request_bytes, req_block_offset));
         pending <= expected_q.size();
      end
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives allocate and free requests into the heap allocator under both fit
// policies, with bursty sending and random response stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import bta_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CMD_ALLOC;
   logic [15:0] req_request_bytes = '0;
   logic [15:0] req_block_offset = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_payload_offset;
   logic [1:0]  rsp_status;
   int          err_count;
   int          pending;
   int          hold_cycles = 0;
   logic [15:0] live_q[$];

   always #5 clock = ~clock;

   boundary_tag_heap_allocator u_dut (.*);
   bta_checker u_chk (.*);

   // remember offsets handed out so frees mostly hit real blocks
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_DONE
          && rsp_payload_offset != 0)
         live_q.push_back(rsp_payload_offset);

   // receiver: long hold-offs on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 2) != 0);
      end
   end

   // hold the request until an edge where stall was low
   task automatic send(logic cmd, logic [15:0] nbytes, logic [15:0] off);
      logic stalled;
      req_cmd           <= cmd;
      req_request_bytes <= nbytes;
      req_block_offset  <= off;
      req_valid         <= 1'b1;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic idle_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   task automatic set_policy(logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_phase(int n);
      int burst, idx;
      logic [15:0] sz;
      logic [15:0] off;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         if (burst == 0) begin
            idle_gap();
            burst = $urandom_range(1, 12);
         end
         burst--;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               sz = 16'($urandom_range(1, 200));
               send(CMD_ALLOC, sz, 16'($urandom));
            end
            4: send(CMD_ALLOC, 16'($urandom), 16'($urandom));
            5: send(CMD_ALLOC,
                    $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(1, 4000)),
                    16'($urandom));
            6, 7, 8: begin
               if (live_q.size() > 0) begin
                  idx = $urandom_range(0, live_q.size() - 1);
                  off = live_q[idx];
                  live_q.delete(idx);
               end else begin
                  off = 16'($urandom);
               end
               send(CMD_FREE, 16'($urandom), off);
            end
            default: send(CMD_FREE, 16'($urandom), 16'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (30) @(posedge clock);

      // directed: edge sizes, zero size, bad frees, double free, growth
      send(CMD_ALLOC, 16'd0, 16'hFFFF);
      send(CMD_ALLOC, 16'd1, 16'd0);
      send(CMD_ALLOC, 16'd8, 16'd0);
      send(CMD_ALLOC, 16'd9, 16'd0);
      send(CMD_ALLOC, 16'd4000, 16'd0);
      send(CMD_ALLOC, 16'd5000, 16'd0);
      send(CMD_FREE, 16'hFFFF, 16'd16);
      send(CMD_FREE, 16'd0, 16'd16);
      send(CMD_FREE, 16'd0, 16'd17);
      send(CMD_FREE, 16'd0, 16'hFFFF);
      send(CMD_FREE, 16'd0, 16'd0);
      send(CMD_ALLOC, 16'd2, 16'd0);
      send(CMD_ALLOC, 16'hFFFF, 16'd0);
      send(CMD_ALLOC, 16'd30000, 16'd0);
      send(CMD_ALLOC, 16'd30000, 16'd0);
      send(CMD_ALLOC, 16'd30000, 16'd0);
      drain();

      // long receiver hold-off while requests keep coming
      hold_cycles = 300;
      random_phase(20);
      drain();

      set_policy(1'b1);
      random_phase(330);
      drain();
      set_policy(1'b0);
      random_phase(330);
      drain();

      if (err_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #200ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

/* boundary_tag_heap_allocator.f */
rtl/bta_pkg.sv
rtl/boundary_tag_heap_allocator.sv
verif/bta_checker.sv
verif/tb_top.sv
